/* sv/jsfe_pkg.sv */
package jsfe_pkg;

    // Key storage is fixed by the four 64-bit key registers.
    localparam int KEY_BYTES_STORED = 32;
    localparam int KEY_MAX_BYTES_DEF = 32;

    // Configuration register indexes.
    localparam logic [2:0] REG_KEY_LOW    = 3'd0;
    localparam logic [2:0] REG_KEY_SECOND = 3'd1;
    localparam logic [2:0] REG_KEY_THIRD  = 3'd2;
    localparam logic [2:0] REG_KEY_HIGH   = 3'd3;
    localparam logic [2:0] REG_KEY_LENGTH = 3'd4;

    // Result kinds.
    localparam logic [2:0] K_BYTE         = 3'd0;
    localparam logic [2:0] K_FOUND        = 3'd1;
    localparam logic [2:0] K_MISSING      = 3'd2;
    localparam logic [2:0] K_NOT_STRING   = 3'd3;
    localparam logic [2:0] K_BAD_HEX      = 3'd4;
    localparam logic [2:0] K_UNTERMINATED = 3'd5;

    // UTF-8 encoding constants.
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [7:0]  UTF8_MASK6 = 8'h3F;
    localparam logic [15:0] UTF8_TWO_LIMIT   = 16'h0080;
    localparam logic [15:0] UTF8_THREE_LIMIT = 16'h0800;

    // Result queue depth, in groups of results of one input beat.
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [8*KEY_BYTES_STORED-1:0] key_bytes;
        logic [5:0]                    key_length;
    } key_cfg_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } result_t;

    // Up to three results caused by one input beat.
    typedef struct packed {
        logic [1:0] count;
        result_t    r2;
        result_t    r1;
        result_t    r0;
    } result_group_t;

endpackage

/* sv/jsfe_cfg_regs.sv */
module jsfe_cfg_regs
    import jsfe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output key_cfg_t    key_cfg
);

    logic [63:0] key_low_reg;
    logic [63:0] key_second_reg;
    logic [63:0] key_third_reg;
    logic [63:0] key_high_reg;
    logic [5:0]  key_length_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Register decode; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg    <= '0;
            key_second_reg <= '0;
            key_third_reg  <= '0;
            key_high_reg   <= '0;
            key_length_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_KEY_LOW:    key_low_reg    <= cfg_data;
                REG_KEY_SECOND: key_second_reg <= cfg_data;
                REG_KEY_THIRD:  key_third_reg  <= cfg_data;
                REG_KEY_HIGH:   key_high_reg   <= cfg_data;
                REG_KEY_LENGTH: key_length_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    assign key_cfg.key_bytes  = {key_high_reg, key_third_reg, key_second_reg, key_low_reg};
    assign key_cfg.key_length = key_length_reg;

endmodule

/* sv/jsfe_parser.sv */
module jsfe_parser
    import jsfe_pkg::*;
#(
    parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    input  logic          end_of_text,
    input  key_cfg_t      key_cfg,
    output result_group_t group
);

    localparam int POS_W = $clog2(KEY_MAX_BYTES + 1);
    localparam int IDX_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

    localparam logic [2:0] PH_SEARCH     = 3'd0;
    localparam logic [2:0] PH_WAIT_VALUE = 3'd1;
    localparam logic [2:0] PH_VALUE      = 3'd2;
    localparam logic [2:0] PH_ESCAPE     = 3'd3;
    localparam logic [2:0] PH_HEX        = 3'd4;
    localparam logic [2:0] PH_DONE       = 3'd5;

    logic [2:0]       phase_reg, phase_next;
    logic [POS_W-1:0] match_pos_reg, match_pos_next;
    logic             match_active_reg, match_active_next;
    logic             awaiting_colon_reg, awaiting_colon_next;
    logic [15:0]      code_point_reg, code_point_next;
    logic [1:0]       hex_seen_reg, hex_seen_next;
    logic             verdict_reg, verdict_next;

    logic [7:0]       key_arr [KEY_MAX_BYTES];
    logic [POS_W-1:0] used_len;
    logic [7:0]       key_byte;
    logic             pos_in_key;
    logic             hex_ok;
    logic [3:0]       hex_val;
    logic [15:0]      cp_new;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
    endfunction

    function automatic logic [2:0] end_verdict(input logic [2:0] ph);
        logic [2:0] k;
        unique case (ph)
            PH_WAIT_VALUE:       k = K_NOT_STRING;
            PH_VALUE, PH_ESCAPE: k = K_UNTERMINATED;
            PH_HEX:              k = K_BAD_HEX;
            default:             k = K_MISSING;
        endcase
        return k;
    endfunction

    // Key bytes in use and the clamped key length.
    always_comb begin
        for (int k = 0; k < KEY_MAX_BYTES; k++) begin
            key_arr[k] = key_cfg.key_bytes[k*8 +: 8];
        end
    end

    assign used_len = (key_cfg.key_length > 6'(KEY_MAX_BYTES)) ? POS_W'(KEY_MAX_BYTES)
                                                                : key_cfg.key_length[POS_W-1:0];
    assign pos_in_key = match_pos_reg < used_len;
    assign key_byte   = pos_in_key ? key_arr[match_pos_reg[IDX_W-1:0]] : 8'h00;

    // Hex digit decode for the \u escape.
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = in_byte[3:0];
        if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
            hex_val = in_byte[3:0];
        end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                     (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
            hex_val = in_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign cp_new = {code_point_reg[11:0], hex_val};

    // Next state and the results of one accepted beat.
    always_comb begin
        phase_next          = phase_reg;
        match_pos_next      = match_pos_reg;
        match_active_next   = match_active_reg;
        awaiting_colon_next = awaiting_colon_reg;
        code_point_next     = code_point_reg;
        hex_seen_next       = hex_seen_reg;
        verdict_next        = verdict_reg;
        group               = '0;

        if (end_of_text) begin
            if (!verdict_reg) begin
                group.count   = 2'd1;
                group.r0.kind = end_verdict(phase_reg);
            end
            phase_next          = PH_SEARCH;
            match_pos_next      = '0;
            match_active_next   = 1'b0;
            awaiting_colon_next = 1'b0;
            code_point_next     = '0;
            hex_seen_next       = '0;
            verdict_next        = 1'b0;
        end else if (verdict_reg) begin
            // Bytes after a verdict are dropped.
        end else if (in_byte == 8'h00) begin
            group.count   = 2'd1;
            group.r0.kind = end_verdict(phase_reg);
            phase_next    = PH_DONE;
            verdict_next  = 1'b1;
        end else begin
            unique case (phase_reg)
                PH_SEARCH: begin
                    if (in_byte == 8'h22) begin
                        awaiting_colon_next = match_active_reg && (match_pos_reg == used_len);
                        match_active_next   = 1'b1;
                        match_pos_next      = '0;
                    end else if (awaiting_colon_reg && in_byte == 8'h3A) begin
                        phase_next          = PH_WAIT_VALUE;
                        awaiting_colon_next = 1'b0;
                        match_active_next   = 1'b0;
                        match_pos_next      = '0;
                    end else begin
                        if (!is_space(in_byte)) begin
                            awaiting_colon_next = 1'b0;
                        end
                        if (match_active_reg) begin
                            if (pos_in_key && in_byte == key_byte) begin
                                match_pos_next = match_pos_reg + 1'b1;
                            end else begin
                                match_active_next = 1'b0;
                                match_pos_next    = '0;
                            end
                        end
                    end
                end
                PH_WAIT_VALUE: begin
                    if (in_byte == 8'h22) begin
                        phase_next = PH_VALUE;
                    end else if (!is_space(in_byte)) begin
                        group.count   = 2'd1;
                        group.r0.kind = K_NOT_STRING;
                        phase_next    = PH_DONE;
                        verdict_next  = 1'b1;
                    end
                end
                PH_VALUE: begin
                    if (in_byte == 8'h5C) begin
                        phase_next = PH_ESCAPE;
                    end else if (in_byte == 8'h22) begin
                        group.count   = 2'd1;
                        group.r0.kind = K_FOUND;
                        phase_next    = PH_DONE;
                        verdict_next  = 1'b1;
                    end else begin
                        group.count   = 2'd1;
                        group.r0.kind = K_BYTE;
                        group.r0.data = in_byte;
                    end
                end
                PH_ESCAPE: begin
                    if (in_byte == 8'h75) begin
                        phase_next      = PH_HEX;
                        code_point_next = '0;
                        hex_seen_next   = '0;
                    end else begin
                        phase_next    = PH_VALUE;
                        group.count   = 2'd1;
                        group.r0.kind = K_BYTE;
                        case (in_byte)
                            8'h6E:   group.r0.data = 8'h0A;
                            8'h72:   group.r0.data = 8'h0D;
                            8'h74:   group.r0.data = 8'h09;
                            8'h62:   group.r0.data = 8'h08;
                            8'h66:   group.r0.data = 8'h0C;
                            default: group.r0.data = in_byte;
                        endcase
                    end
                end
                PH_HEX: begin
                    if (!hex_ok) begin
                        group.count   = 2'd1;
                        group.r0.kind = K_BAD_HEX;
                        phase_next    = PH_DONE;
                        verdict_next  = 1'b1;
                    end else if (hex_seen_reg != 2'd3) begin
                        code_point_next = cp_new;
                        hex_seen_next   = hex_seen_reg + 2'd1;
                    end else begin
                        // Fourth digit: encode the code point as UTF-8.
                        code_point_next = '0;
                        hex_seen_next   = '0;
                        phase_next      = PH_VALUE;
                        group.r0.kind   = K_BYTE;
                        group.r1.kind   = K_BYTE;
                        group.r2.kind   = K_BYTE;
                        if (cp_new < UTF8_TWO_LIMIT) begin
                            group.count   = 2'd1;
                            group.r0.data = cp_new[7:0];
                        end else if (cp_new < UTF8_THREE_LIMIT) begin
                            group.count   = 2'd2;
                            group.r0.data = UTF8_LEAD2 | {3'b000, cp_new[10:6]};
                            group.r1.data = UTF8_CONT | ({2'b00, cp_new[5:0]} & UTF8_MASK6);
                        end else begin
                            group.count   = 2'd3;
                            group.r0.data = UTF8_LEAD3 | {4'h0, cp_new[15:12]};
                            group.r1.data = UTF8_CONT | ({2'b00, cp_new[11:6]} & UTF8_MASK6);
                            group.r2.data = UTF8_CONT | ({2'b00, cp_new[5:0]} & UTF8_MASK6);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_SEARCH;
            match_pos_reg      <= '0;
            match_active_reg   <= 1'b0;
            awaiting_colon_reg <= 1'b0;
            code_point_reg     <= '0;
            hex_seen_reg       <= '0;
            verdict_reg        <= 1'b0;
        end else if (accept) begin
            phase_reg          <= phase_next;
            match_pos_reg      <= match_pos_next;
            match_active_reg   <= match_active_next;
            awaiting_colon_reg <= awaiting_colon_next;
            code_point_reg     <= code_point_next;
            hex_seen_reg       <= hex_seen_next;
            verdict_reg        <= verdict_next;
        end
    end

endmodule

/* sv/jsfe_result_queue.sv */
module jsfe_result_queue
    import jsfe_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  result_group_t push_group,
    output logic          not_full,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [2:0]    m_kind,
    output logic [7:0]    m_out_byte,
    output logic          m_last_of_run
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_group_t    mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [1:0]       sub_reg;
    result_group_t    head;
    result_t          head_res;
    logic             head_last;
    logic             out_beat;
    logic             pop;

    assign not_full = count_reg != CNT_W'(QUEUE_DEPTH);
    assign m_valid  = count_reg != '0;
    assign head     = mem[rd_ptr_reg];

    // Pick the current result of the head group.
    always_comb begin
        case (sub_reg)
            2'd1:    head_res = head.r1;
            2'd2:    head_res = head.r2;
            default: head_res = head.r0;
        endcase
    end

    assign head_last     = sub_reg == (head.count - 2'd1);
    assign m_kind        = head_res.kind;
    assign m_out_byte    = head_res.data;
    assign m_last_of_run = head_last;

    assign out_beat = m_valid && m_ready;
    assign pop      = out_beat && head_last;

    // Group storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_group;
        end
    end

    // Pointers, fill count and position within the head group.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
            if (out_beat) begin
                sub_reg <= head_last ? 2'd0 : sub_reg + 2'd1;
            end
        end
    end

endmodule

/* sv/json_string_field_extractor.sv */
// Streaming JSON string field extractor. Each input beat carries one text byte (or an
// end-of-text mark), and one beat is taken every cycle while the four-group result queue
// has room. The byte updates the parser state in the cycle it is accepted; the results it
// causes (none, one status or value byte, or up to three UTF-8 bytes at the end of a \u
// escape) enter the queue together and leave on the result channel one per cycle while
// m_ready is high. The output channel's rate, with the number of results each beat causes,
// sets the sustained input rate. The user must write the key and its length through the
// configuration channel only while the block is idle; the block does not enforce this.
module json_string_field_extractor
    import jsfe_pkg::*;
#(
    parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_out_byte,
    output logic        m_last_of_run
);

    key_cfg_t      key_cfg;
    result_group_t group;
    logic          in_beat;
    logic          queue_not_full;

    assign s_ready = queue_not_full;
    assign in_beat = s_valid && s_ready;

    // Configuration registers.
    jsfe_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_cfg   (key_cfg)
    );

    // Key match and value decode.
    jsfe_parser #(
        .KEY_MAX_BYTES (KEY_MAX_BYTES)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (in_beat),
        .in_byte     (s_in_byte),
        .end_of_text (s_end_of_text),
        .key_cfg     (key_cfg),
        .group       (group)
    );

    // Result queue and serializer.
    jsfe_result_queue u_queue (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (in_beat && (group.count != 2'd0)),
        .push_group    (group),
        .not_full      (queue_not_full),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

`ifndef SYNTHESIS
    // A status always closes its run and carries a zero byte.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != K_BYTE) |-> (m_last_of_run && m_out_byte == 8'h00))
        else $error("status result without last_of_run or with nonzero byte");

    // Input stalls only when results are waiting.
    a_stall_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with an empty result queue");

    // A value byte that is not the last of its run is followed by another value byte.
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> (m_valid && m_kind == K_BYTE))
        else $error("run of results broken");
`endif

endmodule
